FILE: rtl/rdd_pkg.sv
// Shared types and constants for the rotary dial digit decoder.
// No dependencies; every other file of the block depends on this package.
package rdd_pkg;

  localparam int unsigned ELAPSED_W = 8;
  localparam int unsigned COUNT_W   = 4;
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned LEN_W     = 5;
  localparam int unsigned GUARD_W   = 8;

  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [LEN_W-1:0] NUMBER_CAPACITY  = 5'd20;
  localparam logic [LEN_W-1:0] COMMAND_CAPACITY = 5'd22;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 8'd255;
  localparam logic [COUNT_W-1:0]   COUNT_MAX   = 4'd15;
  localparam logic [COUNT_W-1:0]   TEN_PULSES  = 4'd10;

  localparam logic [GUARD_W-1:0] PULSE_GUARD_RST = 8'd20;
  localparam logic [GUARD_W-1:0] STOP_GUARD_RST  = 8'd40;
  localparam logic [GUARD_W-1:0] HOOK_GUARD_RST  = 8'd50;

  typedef enum logic [1:0] {
    REG_PULSE_GUARD = 2'd0,
    REG_STOP_GUARD  = 2'd1,
    REG_HOOK_GUARD  = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [GUARD_W-1:0] pulse;
    logic [GUARD_W-1:0] stop;
    logic [GUARD_W-1:0] hook;
  } guard_cfg_t;

  typedef struct packed {
    logic tick;
    logic hook_level;
    logic pulse_level;
    logic stop_level;
  } line_item_t;

  typedef struct packed {
    logic               digit_stored;
    logic [DIGIT_W-1:0] digit_value;
    logic               to_command;
    logic [LEN_W-1:0]   digit_position;
    logic               hook_down;
    logic [LEN_W-1:0]   number_length;
    logic [LEN_W-1:0]   command_length;
  } result_t;

endpackage

FILE: rtl/rdd_if.sv
// Valid/ready channel interfaces for the line samples and the digit results.
// Depends on rdd_pkg for field widths.
interface rdd_in_if;
  logic valid;
  logic ready;
  logic tick;
  logic hook_level;
  logic pulse_level;
  logic stop_level;

  modport source (output valid, tick, hook_level, pulse_level, stop_level, input ready);
  modport sink   (input valid, tick, hook_level, pulse_level, stop_level, output ready);
endinterface

interface rdd_out_if;
  logic                       valid;
  logic                       ready;
  logic                       digit_stored;
  logic [rdd_pkg::DIGIT_W-1:0] digit_value;
  logic                       to_command;
  logic [rdd_pkg::LEN_W-1:0]  digit_position;
  logic                       hook_down;
  logic [rdd_pkg::LEN_W-1:0]  number_length;
  logic [rdd_pkg::LEN_W-1:0]  command_length;

  modport source (output valid, digit_stored, digit_value, to_command, digit_position,
                  hook_down, number_length, command_length, input ready);
  modport sink   (input valid, digit_stored, digit_value, to_command, digit_position,
                  hook_down, number_length, command_length, output ready);
endinterface

FILE: rtl/rdd_cfg.sv
// APB register file holding the three guard times.
// Depends on rdd_pkg.
module rdd_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rdd_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [rdd_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [rdd_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  output rdd_pkg::guard_cfg_t             guard_o
);
  import rdd_pkg::*;

  guard_cfg_t guard_q;
  guard_cfg_t guard_d;
  reg_idx_e   idx;
  logic       wr_en;

  assign idx    = reg_idx_e'(paddr[APB_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    guard_d = guard_q;
    if (wr_en) begin
      case (idx)
        REG_PULSE_GUARD: guard_d.pulse = pwdata[GUARD_W-1:0];
        REG_STOP_GUARD:  guard_d.stop  = pwdata[GUARD_W-1:0];
        REG_HOOK_GUARD:  guard_d.hook  = pwdata[GUARD_W-1:0];
        default:         guard_d = guard_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PULSE_GUARD: prdata = {{(APB_DATA_W-GUARD_W){1'b0}}, guard_q.pulse};
      REG_STOP_GUARD:  prdata = {{(APB_DATA_W-GUARD_W){1'b0}}, guard_q.stop};
      REG_HOOK_GUARD:  prdata = {{(APB_DATA_W-GUARD_W){1'b0}}, guard_q.hook};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      guard_q.pulse <= PULSE_GUARD_RST;
      guard_q.stop  <= STOP_GUARD_RST;
      guard_q.hook  <= HOOK_GUARD_RST;
    end else begin
      guard_q <= guard_d;
    end
  end

  assign guard_o = guard_q;

endmodule

FILE: rtl/rdd_core.sv
// Line guard timers, edge qualification, pulse counting and list bookkeeping.
// Depends on rdd_pkg; computes one result per transferred line sample.
module rdd_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rdd_pkg::guard_cfg_t guard_i,
  input  logic                accept_i,
  input  rdd_pkg::line_item_t item_i,
  output rdd_pkg::result_t    result_o
);
  import rdd_pkg::*;

  logic [ELAPSED_W-1:0] hook_elapsed_q, hook_elapsed_d;
  logic [ELAPSED_W-1:0] pulse_elapsed_q, pulse_elapsed_d;
  logic [ELAPSED_W-1:0] stop_elapsed_q, stop_elapsed_d;
  logic                 prev_hook_q, prev_pulse_q, prev_stop_q;
  logic                 hook_state_q, hook_state_d;
  logic [COUNT_W-1:0]   pulse_count_q, pulse_count_d;
  logic [LEN_W-1:0]     num_len_q, num_len_d;
  logic [LEN_W-1:0]     cmd_len_q, cmd_len_d;

  logic [ELAPSED_W-1:0] hook_t, pulse_t, stop_t;
  logic                 hook_acc, pulse_acc, stop_acc;
  logic [COUNT_W-1:0]   cnt_mid;
  logic [LEN_W-1:0]     num_mid, cmd_mid;
  logic [DIGIT_W-1:0]   digit;

  function automatic logic [ELAPSED_W-1:0] advance(input logic [ELAPSED_W-1:0] t);
    return (t < ELAPSED_MAX) ? t + 1'b1 : ELAPSED_MAX;
  endfunction

  always_comb begin
    hook_t  = item_i.tick ? advance(hook_elapsed_q)  : hook_elapsed_q;
    pulse_t = item_i.tick ? advance(pulse_elapsed_q) : pulse_elapsed_q;
    stop_t  = item_i.tick ? advance(stop_elapsed_q)  : stop_elapsed_q;

    hook_acc  = (item_i.hook_level != prev_hook_q) && (hook_t >= guard_i.hook);
    pulse_acc = (item_i.pulse_level != prev_pulse_q) && (pulse_t > guard_i.pulse);
    stop_acc  = (item_i.stop_level != prev_stop_q) && (stop_t > guard_i.stop);

    hook_state_d    = hook_acc ? item_i.hook_level : hook_state_q;
    num_mid         = (hook_acc && item_i.hook_level) ? '0 : num_len_q;
    cmd_mid         = (hook_acc && !item_i.hook_level) ? '0 : cmd_len_q;
    hook_elapsed_d  = hook_acc ? '0 : hook_t;

    cnt_mid         = (pulse_acc && item_i.pulse_level && (pulse_count_q < COUNT_MAX))
                      ? pulse_count_q + 1'b1 : pulse_count_q;
    pulse_elapsed_d = pulse_acc ? '0 : pulse_t;

    stop_elapsed_d  = stop_acc ? '0 : stop_t;
    digit           = (cnt_mid == TEN_PULSES) ? '0 : cnt_mid;

    pulse_count_d = cnt_mid;
    num_len_d     = num_mid;
    cmd_len_d     = cmd_mid;
    result_o      = '0;
    if (stop_acc && item_i.stop_level && (cnt_mid != '0)) begin
      pulse_count_d = '0;
      if (hook_state_d) begin
        if (cmd_mid < COMMAND_CAPACITY) begin
          result_o.digit_stored   = 1'b1;
          result_o.digit_value    = digit;
          result_o.to_command     = 1'b1;
          result_o.digit_position = cmd_mid;
          cmd_len_d               = cmd_mid + 1'b1;
        end
      end else begin
        if (num_mid < NUMBER_CAPACITY) begin
          result_o.digit_stored   = 1'b1;
          result_o.digit_value    = digit;
          result_o.digit_position = num_mid;
          num_len_d               = num_mid + 1'b1;
        end
      end
    end
    result_o.hook_down      = hook_state_d;
    result_o.number_length  = num_len_d;
    result_o.command_length = cmd_len_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hook_elapsed_q  <= '0;
      pulse_elapsed_q <= '0;
      stop_elapsed_q  <= '0;
      prev_hook_q     <= 1'b1;
      prev_pulse_q    <= 1'b1;
      prev_stop_q     <= 1'b1;
      hook_state_q    <= 1'b1;
      pulse_count_q   <= '0;
      num_len_q       <= '0;
      cmd_len_q       <= '0;
    end else if (accept_i) begin
      hook_elapsed_q  <= hook_elapsed_d;
      pulse_elapsed_q <= pulse_elapsed_d;
      stop_elapsed_q  <= stop_elapsed_d;
      prev_hook_q     <= item_i.hook_level;
      prev_pulse_q    <= item_i.pulse_level;
      prev_stop_q     <= item_i.stop_level;
      hook_state_q    <= hook_state_d;
      pulse_count_q   <= pulse_count_d;
      num_len_q       <= num_len_d;
      cmd_len_q       <= cmd_len_d;
    end
  end

`ifndef SYNTH
  a_num_len_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    num_len_q <= NUMBER_CAPACITY)
    else $error("number list length beyond capacity");

  a_cmd_len_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_len_q <= COMMAND_CAPACITY)
    else $error("command list length beyond capacity");

  a_digit_clears_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && result_o.digit_stored |=> pulse_count_q == '0)
    else $error("pulse count not cleared after stored digit");

  a_hook_change_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && (hook_state_d != hook_state_q) |=> hook_elapsed_q == '0)
    else $error("hook timer not cleared on accepted hook change");
`endif

endmodule

FILE: rtl/rotary_dial_digit_decoder.sv
// Top level of the rotary dial digit decoder: APB guard registers, decode core
// and a registered result stage. Depends on rdd_pkg, rdd_if, rdd_cfg, rdd_core.
//
// A line sample is taken per clock while ready; each yields exactly one result,
// presented in the cycle after its transfer from the output register. A new
// sample is taken in every cycle while the output register is empty or being
// read in that same cycle, so the block sustains one item per clock; input
// ready drops only while a held result waits on output ready. Guard registers
// reset to 20, 40 and 50 ms and may be rewritten over APB while idle.
module rotary_dial_digit_decoder (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  rdd_in_if.sink                          in_i,
  rdd_out_if.source                       out_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rdd_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [rdd_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [rdd_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import rdd_pkg::*;

  guard_cfg_t guard;
  line_item_t item;
  result_t    result;
  result_t    res_q;
  logic       valid_q, valid_d;
  logic       accept;

  assign in_i.ready = !valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign item       = '{tick:        in_i.tick,
                        hook_level:  in_i.hook_level,
                        pulse_level: in_i.pulse_level,
                        stop_level:  in_i.stop_level};

  rdd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .guard_o (guard)
  );

  rdd_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .guard_i  (guard),
    .accept_i (accept),
    .item_i   (item),
    .result_o (result)
  );

  assign valid_d = accept || (valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= result;
    end
  end

  assign out_o.valid          = valid_q;
  assign out_o.digit_stored   = res_q.digit_stored;
  assign out_o.digit_value    = res_q.digit_value;
  assign out_o.to_command     = res_q.to_command;
  assign out_o.digit_position = res_q.digit_position;
  assign out_o.hook_down      = res_q.hook_down;
  assign out_o.number_length  = res_q.number_length;
  assign out_o.command_length = res_q.command_length;

endmodule
